// ===== hdl/bitwise_shift_vector_unit_core_defines.svh =====
// Assertion macros shared by the RTL of the logic and shift unit.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef BITWISE_SHIFT_VECTOR_UNIT_CORE_DEFINES_SVH
`define BITWISE_SHIFT_VECTOR_UNIT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on the rising clock edge, ignored while reset is high.
`define BSVU_ASSERT(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("bsvu assertion failed");

// Check a property on the rising clock edge, also during reset.
`define BSVU_ASSERT_ALWAYS(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) (prop)) \
    else $error("bsvu assertion failed");

`else

`define BSVU_ASSERT(lbl, clk_sig, rst_sig, prop)
`define BSVU_ASSERT_ALWAYS(lbl, clk_sig, prop)

`endif

`endif

// ===== hdl/bsvu_pkg.sv =====
// Shared types and constants of the logic and shift unit: operation codes,
// the decoded control word and operand widths. No dependencies.
package bsvu_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned MAX_LANES  = 4;
  localparam int unsigned VEC_W      = WORD_W * MAX_LANES;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned FUNC_W     = 5;
  localparam int unsigned SHAMT_W    = 5;
  localparam int unsigned IMM_W      = 32;
  localparam int unsigned IMM8_W     = 8;
  localparam int unsigned BYTES_W    = WORD_W / 8;
  localparam int unsigned BYTE_CNT_W = 4;
  localparam int unsigned PCNT_W     = 6;

  // Operation codes.
  localparam logic [FUNC_W-1:0] OP_AND    = 5'd0;
  localparam logic [FUNC_W-1:0] OP_OR     = 5'd1;
  localparam logic [FUNC_W-1:0] OP_XOR    = 5'd2;
  localparam logic [FUNC_W-1:0] OP_NOR    = 5'd3;
  localparam logic [FUNC_W-1:0] OP_ANDN   = 5'd4;
  localparam logic [FUNC_W-1:0] OP_NOT    = 5'd5;
  localparam logic [FUNC_W-1:0] OP_ORI16  = 5'd6;
  localparam logic [FUNC_W-1:0] OP_ANDI16 = 5'd7;
  localparam logic [FUNC_W-1:0] OP_ORI    = 5'd8;
  localparam logic [FUNC_W-1:0] OP_XORI   = 5'd9;
  localparam logic [FUNC_W-1:0] OP_ANDI   = 5'd10;
  localparam logic [FUNC_W-1:0] OP_ANDNI  = 5'd11;
  localparam logic [FUNC_W-1:0] OP_SRA1   = 5'd12;
  localparam logic [FUNC_W-1:0] OP_SRL1   = 5'd13;
  localparam logic [FUNC_W-1:0] OP_SEXT8  = 5'd14;
  localparam logic [FUNC_W-1:0] OP_SLL    = 5'd15;
  localparam logic [FUNC_W-1:0] OP_SRL    = 5'd16;
  localparam logic [FUNC_W-1:0] OP_SRA    = 5'd17;
  localparam logic [FUNC_W-1:0] OP_SLLI   = 5'd18;
  localparam logic [FUNC_W-1:0] OP_SRLI   = 5'd19;
  localparam logic [FUNC_W-1:0] OP_SRAI   = 5'd20;
  localparam logic [FUNC_W-1:0] OP_LSA    = 5'd21;
  localparam logic [FUNC_W-1:0] OP_PCNT   = 5'd22;
  localparam logic [FUNC_W-1:0] OP_ANDV   = 5'd23;
  localparam logic [FUNC_W-1:0] OP_ORV    = 5'd24;
  localparam logic [FUNC_W-1:0] OP_XORV   = 5'd25;
  localparam logic [FUNC_W-1:0] OP_SLLIW  = 5'd26;
  localparam logic [FUNC_W-1:0] OP_BMNZ   = 5'd27;
  localparam logic [FUNC_W-1:0] OP_BSELI  = 5'd28;

  // Kind of work a lane does for one request.
  typedef enum logic [3:0] {
    K_ZERO,
    K_LOGIC,
    K_SHL,
    K_SHR,
    K_SRA,
    K_SEXT8,
    K_LSA,
    K_PCNT,
    K_BMNZ,
    K_BSEL
  } kind_t;

  typedef enum logic [2:0] {
    L_AND,
    L_OR,
    L_XOR,
    L_NOR,
    L_ANDN,
    L_NOT
  } lop_t;

  typedef struct packed {
    kind_t kind;
    lop_t  lop;
    logic  vector;
    logic  carry;
    logic  carry_wr;
  } ctrl_t;

endpackage

// ===== hdl/bitwise_shift_vector_unit_core.sv =====
// Top level of the logic and shift unit: stream ports, stage valids and the
// ready chain. Depends on bsvu_pkg, bsvu_decode, bsvu_lane and the defines header.
//
// Usage:
//   One request on the s_ group carries one instruction: operation code,
//   three 128-bit operands, an immediate and an lsa amount. One result per
//   request leaves on the m_ group: 128-bit result plus carry_out and
//   carry_written. Results leave in request order.
//   Pipeline: three register stages (decode, execute, finish). A request
//   accepted into decode is registered in execute and then in finish, whose
//   register drives m_tvalid and the result.
//   Throughput: one request per cycle while m_tready is high; each stage holds
//   one request and passes it on whenever the stage after it is empty or moving.
//   Stall: while m_tready is low the output holds its result and the earlier
//   stages keep filling; s_tready drops once all three stages are full.
//   Reset: rst clears the stage valid bits; the block is ready as soon as
//   reset is released. There is no state beyond the pipeline.
//   LANES (1 to 4) sets how many 32-bit lanes exist; lanes above it read zero.
`include "bitwise_shift_vector_unit_core_defines.svh"

module bitwise_shift_vector_unit_core
  import bsvu_pkg::*;
#(
  parameter int unsigned LANES = 4
)
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // From bit 0: func[5], src_a_low[64], src_a_high[64], src_b_low[64],
  // src_b_high[64], old_dest_low[64], old_dest_high[64], immediate[32],
  // lsa_shift[5], zero fill[6].
  input  logic [431:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // From bit 0: result_low[64], result_high[64], carry_out[1],
  // carry_written[1], zero fill[6].
  output logic [135:0] m_tdata
);

  localparam int unsigned IN_FUNC  = 0;
  localparam int unsigned IN_AL    = IN_FUNC + FUNC_W;
  localparam int unsigned IN_AH    = IN_AL + HALF_W;
  localparam int unsigned IN_BL    = IN_AH + HALF_W;
  localparam int unsigned IN_BH    = IN_BL + HALF_W;
  localparam int unsigned IN_OL    = IN_BH + HALF_W;
  localparam int unsigned IN_OH    = IN_OL + HALF_W;
  localparam int unsigned IN_IMM   = IN_OH + HALF_W;
  localparam int unsigned IN_LSA   = IN_IMM + IMM_W;
  localparam int unsigned OUT_COUT = VEC_W;
  localparam int unsigned OUT_CWR  = VEC_W + 1;
  localparam int unsigned OUT_PAD  = 136 - (VEC_W + 2);

  logic [VEC_W-1:0]   src_a;
  logic [VEC_W-1:0]   src_b;
  logic [VEC_W-1:0]   old_dest;

  ctrl_t              ctrl1;
  logic [VEC_W-1:0]   opa1;
  logic [VEC_W-1:0]   op21;
  logic [VEC_W-1:0]   old1;
  logic [IMM8_W-1:0]  imm81;
  logic [SHAMT_W-1:0] shamt1;
  logic [SHAMT_W-1:0] lsa_sh1;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic carry2, carry_wr2, carry3, carry_wr3;

  logic [MAX_LANES-1:0][WORD_W-1:0] lane_res;

  assign src_a    = {s_tdata[IN_AH +: HALF_W], s_tdata[IN_AL +: HALF_W]};
  assign src_b    = {s_tdata[IN_BH +: HALF_W], s_tdata[IN_BL +: HALF_W]};
  assign old_dest = {s_tdata[IN_OH +: HALF_W], s_tdata[IN_OL +: HALF_W]};

  // A stage loads when it is empty or its content moves on this cycle.
  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign m_tvalid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      carry2    <= ctrl1.carry;
      carry_wr2 <= ctrl1.carry_wr;
    end
    if (rdy3) begin
      carry3    <= carry2;
      carry_wr3 <= carry_wr2;
    end
  end

  bsvu_decode u_decode (
    .clk       (clk),
    .en        (rdy1),
    .func      (s_tdata[IN_FUNC +: FUNC_W]),
    .src_a     (src_a),
    .src_b     (src_b),
    .old_dest  (old_dest),
    .immediate (s_tdata[IN_IMM +: IMM_W]),
    .lsa_shift (s_tdata[IN_LSA +: SHAMT_W]),
    .ctrl      (ctrl1),
    .opa       (opa1),
    .op2       (op21),
    .old       (old1),
    .imm8      (imm81),
    .shamt     (shamt1),
    .lsa_sh    (lsa_sh1)
  );

  for (genvar k = 0; k < MAX_LANES; k++) begin : g_lane
    if (k < LANES) begin : g_on
      bsvu_lane #(
        .LANE_IDX (k)
      ) u_lane (
        .clk    (clk),
        .en2    (rdy2),
        .en3    (rdy3),
        .ctrl   (ctrl1),
        .opa    (opa1[k*WORD_W +: WORD_W]),
        .op2    (op21[k*WORD_W +: WORD_W]),
        .old    (old1[k*WORD_W +: WORD_W]),
        .imm8   (imm81),
        .shamt  (shamt1),
        .lsa_sh (lsa_sh1),
        .result (lane_res[k])
      );
    end else begin : g_off
      assign lane_res[k] = '0;
    end
  end

  assign m_tdata = {{OUT_PAD{1'b0}}, carry_wr3, carry3, lane_res};

  // A carry is only reported by the shift-by-one operations, which are scalar.
  `BSVU_ASSERT(a_carry_needs_write, clk, rst, m_tvalid && m_tdata[OUT_COUT] |-> m_tdata[OUT_CWR])
  `BSVU_ASSERT(a_carry_op_scalar, clk, rst, m_tvalid && m_tdata[OUT_CWR] |-> m_tdata[VEC_W-1:WORD_W] == '0)
  // Back-pressure reaches the input only with every stage occupied.
  `BSVU_ASSERT(a_full_when_blocked, clk, rst, !s_tready |-> v1 && v2 && v3 && !m_tready)
  // A request in the execute stage is never dropped on its way to the output.
  `BSVU_ASSERT(a_stage_advance, clk, rst, v2 && rdy3 |=> v3)

endmodule

// ===== hdl/bsvu_decode.sv =====
// First pipeline stage: decodes the operation code and selects the second
// operand and shift amount. Depends on bsvu_pkg.
module bsvu_decode
  import bsvu_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [FUNC_W-1:0]   func,
  input  logic [VEC_W-1:0]    src_a,
  input  logic [VEC_W-1:0]    src_b,
  input  logic [VEC_W-1:0]    old_dest,
  input  logic [IMM_W-1:0]    immediate,
  input  logic [SHAMT_W-1:0]  lsa_shift,
  output ctrl_t               ctrl,
  output logic [VEC_W-1:0]    opa,
  output logic [VEC_W-1:0]    op2,
  output logic [VEC_W-1:0]    old,
  output logic [IMM8_W-1:0]   imm8,
  output logic [SHAMT_W-1:0]  shamt,
  output logic [SHAMT_W-1:0]  lsa_sh
);

  ctrl_t               ctrl_next;
  logic [WORD_W-1:0]   op2_lane0;
  logic [SHAMT_W-1:0]  shamt_next;
  logic [VEC_W-1:0]    op2_next;

  always_comb begin
    ctrl_next          = '0;
    ctrl_next.kind     = K_ZERO;
    ctrl_next.lop      = L_AND;
    op2_lane0          = src_b[WORD_W-1:0];
    shamt_next         = immediate[SHAMT_W-1:0];
    unique case (func)
      OP_AND:    begin ctrl_next.kind = K_LOGIC; ctrl_next.lop = L_AND;  end
      OP_OR:     begin ctrl_next.kind = K_LOGIC; ctrl_next.lop = L_OR;   end
      OP_XOR:    begin ctrl_next.kind = K_LOGIC; ctrl_next.lop = L_XOR;  end
      OP_NOR:    begin ctrl_next.kind = K_LOGIC; ctrl_next.lop = L_NOR;  end
      OP_ANDN:   begin ctrl_next.kind = K_LOGIC; ctrl_next.lop = L_ANDN; end
      OP_NOT:    begin ctrl_next.kind = K_LOGIC; ctrl_next.lop = L_NOT;  end
      OP_ORI16: begin
        ctrl_next.kind = K_LOGIC;
        ctrl_next.lop  = L_OR;
        op2_lane0      = {16'b0, immediate[15:0]};
      end
      OP_ANDI16: begin
        ctrl_next.kind = K_LOGIC;
        ctrl_next.lop  = L_AND;
        op2_lane0      = {16'b0, immediate[15:0]};
      end
      OP_ORI: begin
        ctrl_next.kind = K_LOGIC;
        ctrl_next.lop  = L_OR;
        op2_lane0      = immediate;
      end
      OP_XORI: begin
        ctrl_next.kind = K_LOGIC;
        ctrl_next.lop  = L_XOR;
        op2_lane0      = immediate;
      end
      OP_ANDI: begin
        ctrl_next.kind = K_LOGIC;
        ctrl_next.lop  = L_AND;
        op2_lane0      = immediate;
      end
      OP_ANDNI: begin
        ctrl_next.kind = K_LOGIC;
        ctrl_next.lop  = L_ANDN;
        op2_lane0      = immediate;
      end
      OP_SRA1: begin
        ctrl_next.kind     = K_SRA;
        ctrl_next.carry    = src_a[0];
        ctrl_next.carry_wr = 1'b1;
        shamt_next         = SHAMT_W'(1);
      end
      OP_SRL1: begin
        ctrl_next.kind     = K_SHR;
        ctrl_next.carry    = src_a[0];
        ctrl_next.carry_wr = 1'b1;
        shamt_next         = SHAMT_W'(1);
      end
      OP_SEXT8:  ctrl_next.kind = K_SEXT8;
      OP_SLL: begin ctrl_next.kind = K_SHL; shamt_next = src_b[SHAMT_W-1:0]; end
      OP_SRL: begin ctrl_next.kind = K_SHR; shamt_next = src_b[SHAMT_W-1:0]; end
      OP_SRA: begin ctrl_next.kind = K_SRA; shamt_next = src_b[SHAMT_W-1:0]; end
      OP_SLLI:   ctrl_next.kind = K_SHL;
      OP_SRLI:   ctrl_next.kind = K_SHR;
      OP_SRAI:   ctrl_next.kind = K_SRA;
      OP_LSA:    ctrl_next.kind = K_LSA;
      OP_PCNT:  begin ctrl_next.kind = K_PCNT; ctrl_next.vector = 1'b1; end
      OP_ANDV: begin
        ctrl_next.kind = K_LOGIC; ctrl_next.lop = L_AND; ctrl_next.vector = 1'b1;
      end
      OP_ORV: begin
        ctrl_next.kind = K_LOGIC; ctrl_next.lop = L_OR;  ctrl_next.vector = 1'b1;
      end
      OP_XORV: begin
        ctrl_next.kind = K_LOGIC; ctrl_next.lop = L_XOR; ctrl_next.vector = 1'b1;
      end
      OP_SLLIW: begin ctrl_next.kind = K_SHL;  ctrl_next.vector = 1'b1; end
      OP_BMNZ:  begin ctrl_next.kind = K_BMNZ; ctrl_next.vector = 1'b1; end
      OP_BSELI: begin ctrl_next.kind = K_BSEL; ctrl_next.vector = 1'b1; end
      default:  ctrl_next.kind = K_ZERO;
    endcase
    op2_next = {src_b[VEC_W-1:WORD_W], op2_lane0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl   <= ctrl_next;
      opa    <= src_a;
      op2    <= op2_next;
      old    <= old_dest;
      imm8   <= immediate[IMM8_W-1:0];
      shamt  <= shamt_next;
      lsa_sh <= lsa_shift;
    end
  end

endmodule

// ===== hdl/bsvu_lane.sv =====
// One 32-bit lane: second stage does logic, shifts and byte popcounts,
// third stage finishes the lsa add and the popcount sum. Depends on bsvu_pkg.
module bsvu_lane
  import bsvu_pkg::*;
#(
  parameter int unsigned LANE_IDX = 0
)
(
  input  logic               clk,
  input  logic               en2,
  input  logic               en3,
  input  ctrl_t              ctrl,
  input  logic [WORD_W-1:0]  opa,
  input  logic [WORD_W-1:0]  op2,
  input  logic [WORD_W-1:0]  old,
  input  logic [IMM8_W-1:0]  imm8,
  input  logic [SHAMT_W-1:0] shamt,
  input  logic [SHAMT_W-1:0] lsa_sh,
  output logic [WORD_W-1:0]  result
);

  typedef enum logic [1:0] {
    F_PASS,
    F_ADD,
    F_PCNT
  } fin_t;

  function automatic logic [BYTE_CNT_W-1:0] byte_count(input logic [7:0] v);
    logic [BYTE_CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + BYTE_CNT_W'(v[i]);
    end
    return n;
  endfunction

  kind_t                               kind_eff;
  fin_t                                fin_next;
  logic [WORD_W-1:0]                   pre_next;
  logic [BYTES_W-1:0][BYTE_CNT_W-1:0]  cnt_next;

  fin_t                                fin;
  logic [WORD_W-1:0]                   pre;
  logic [WORD_W-1:0]                   addend;
  logic [BYTES_W-1:0][BYTE_CNT_W-1:0]  cnt;

  logic [PCNT_W-1:0]                   pcnt_sum;
  logic [WORD_W-1:0]                   result_next;

  // Scalar operations only ever produce a value in lane zero.
  always_comb begin
    kind_eff = ctrl.kind;
    if (LANE_IDX != 0 && !ctrl.vector) begin
      kind_eff = K_ZERO;
    end
  end

  always_comb begin
    fin_next = F_PASS;
    pre_next = '0;
    for (int j = 0; j < BYTES_W; j++) begin
      cnt_next[j] = byte_count(opa[j*8 +: 8]);
    end
    unique case (kind_eff)
      K_LOGIC: begin
        unique case (ctrl.lop)
          L_AND:   pre_next = opa & op2;
          L_OR:    pre_next = opa | op2;
          L_XOR:   pre_next = opa ^ op2;
          L_NOR:   pre_next = ~(opa | op2);
          L_ANDN:  pre_next = opa & ~op2;
          L_NOT:   pre_next = ~opa;
          default: pre_next = '0;
        endcase
      end
      K_SHL:   pre_next = opa << shamt;
      K_SHR:   pre_next = opa >> shamt;
      K_SRA:   pre_next = WORD_W'($signed(opa) >>> shamt);
      K_SEXT8: pre_next = {{(WORD_W-8){opa[7]}}, opa[7:0]};
      K_LSA: begin
        fin_next = F_ADD;
        pre_next = opa << lsa_sh;
      end
      K_PCNT:  fin_next = F_PCNT;
      K_BMNZ:  pre_next = (opa & op2) | (old & ~op2);
      K_BSEL:  pre_next = (opa & ~old) | ({BYTES_W{imm8}} & old);
      default: pre_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      fin    <= fin_next;
      pre    <= pre_next;
      addend <= op2;
      cnt    <= cnt_next;
    end
  end

  always_comb begin
    pcnt_sum = '0;
    for (int j = 0; j < BYTES_W; j++) begin
      pcnt_sum = pcnt_sum + PCNT_W'(cnt[j]);
    end
    unique case (fin)
      F_ADD:   result_next = pre + addend;
      F_PCNT:  result_next = WORD_W'(pcnt_sum);
      default: result_next = pre;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      result <= result_next;
    end
  end

endmodule
